FILE: rtl/core/strq_pkg.sv
// Shared types and constants for the sparse table range query core.
// No dependencies.
`timescale 1ns / 1ps
package strq_pkg;

    localparam int IDX_W  = 10;
    localparam int VAL_W  = 32;
    localparam int CNT_W  = 11;
    localparam int OPC_W  = 2;
    localparam int STAT_W = 2;
    localparam int CFG_IDX_W = 1;

    localparam logic [OPC_W-1:0] OPC_LOAD     = 2'd0;
    localparam logic [OPC_W-1:0] OPC_BUILD    = 2'd1;
    localparam logic [OPC_W-1:0] OPC_OVERLAP  = 2'd2;
    localparam logic [OPC_W-1:0] OPC_DISJOINT = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE    = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOTBUILT = 2'd2;

    localparam logic [2:0] CMB_MIN = 3'd0;
    localparam logic [2:0] CMB_MAX = 3'd1;
    localparam logic [2:0] CMB_SUM = 3'd2;
    localparam logic [2:0] CMB_AND = 3'd3;
    localparam logic [2:0] CMB_OR  = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_COMBINE_OP    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ELEMENT_COUNT = 1'd1;

    // Datapath commands issued by the controller each cycle
    typedef enum logic [2:0] {
        DP_NOP,
        DP_LOAD,      // write base element
        DP_RD_A,      // read store at address A
        DP_RD_B,      // read store at address B
        DP_WR_MERGE,  // write merge(a, b) / a
        DP_ACC_FIRST, // acc = read data
        DP_ACC_MERGE  // acc = merge(acc, read data)
    } dp_op_t;

    typedef struct packed {
        dp_op_t                 op;
        logic [4:0]             rd_level; // only low bits used
        logic [16:0]            rd_pos;
        logic [4:0]             wr_level;
        logic [16:0]            wr_pos;
        logic                   use_b;    // merge b into a on write
    } dp_cmd_t;

endpackage

FILE: rtl/core/strq_if.sv
// Valid/ready channel interfaces for the range query core.
// Depends on strq_pkg.
`timescale 1ns / 1ps
interface strq_in_if;
    import strq_pkg::*;
    logic             valid;
    logic             ready;
    logic [OPC_W-1:0] opcode;
    logic [IDX_W-1:0] left_index;
    logic [IDX_W-1:0] right_index;
    logic [VAL_W-1:0] element_value;
    modport source (output valid, opcode, left_index, right_index, element_value,
                    input ready);
    modport sink   (input valid, opcode, left_index, right_index, element_value,
                    output ready);
endinterface

interface strq_out_if;
    import strq_pkg::*;
    logic              valid;
    logic              ready;
    logic [OPC_W-1:0]  answer_kind;
    logic [VAL_W-1:0]  answer_value;
    logic [STAT_W-1:0] status;
    modport source (output valid, answer_kind, answer_value, status, input ready);
    modport sink   (input valid, answer_kind, answer_value, status, output ready);
endinterface

FILE: rtl/core/strq_datapath.sv
// Level store memory, combine unit and accumulator.
// Depends on strq_pkg.
`timescale 1ns / 1ps
module strq_datapath #(
    parameter int DEPTH      = 1024,
    parameter int LEVELS     = 11,
    parameter int DATA_WIDTH = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  strq_pkg::dp_cmd_t     cmd,
    input  logic [2:0]            combine_op,
    input  logic [DATA_WIDTH-1:0] load_value,
    output logic [DATA_WIDTH-1:0] acc
);
    import strq_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int AW = $clog2(LEVELS * DEPTH);

    logic [DATA_WIDTH-1:0] mem [LEVELS*DEPTH];
    logic [DATA_WIDTH-1:0] rdata_reg;
    logic [DATA_WIDTH-1:0] a_reg;
    logic [DATA_WIDTH-1:0] acc_reg;
    logic [DATA_WIDTH-1:0] wdata;
    logic [AW-1:0]         raddr;
    logic [AW-1:0]         waddr;
    logic                  we;

    function automatic logic [DATA_WIDTH-1:0] merge(input logic [2:0] op,
        input logic [DATA_WIDTH-1:0] x, input logic [DATA_WIDTH-1:0] y);
        case (op)
            CMB_MAX: merge = (x > y) ? x : y;
            CMB_SUM: merge = x + y;
            CMB_AND: merge = x & y;
            CMB_OR:  merge = x | y;
            default: merge = (x < y) ? x : y;
        endcase
    endfunction

    // Flatten level and position into one address
    assign raddr = AW'(cmd.rd_level[LW-1:0]) * AW'(DEPTH) + AW'(cmd.rd_pos[PW-1:0]);
    assign waddr = (cmd.op == DP_LOAD) ? AW'(cmd.wr_pos[PW-1:0])
                 : AW'(cmd.wr_level[LW-1:0]) * AW'(DEPTH) + AW'(cmd.wr_pos[PW-1:0]);
    assign we    = (cmd.op == DP_LOAD) || (cmd.op == DP_WR_MERGE);
    assign wdata = (cmd.op == DP_LOAD) ? load_value
                 : (cmd.use_b ? merge(combine_op, a_reg, rdata_reg) : a_reg);

    // Store port: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    // Hold first operand and accumulator
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg   <= '0;
            acc_reg <= '0;
        end
        else
        begin
            if (cmd.op == DP_RD_B)
            begin
                a_reg <= rdata_reg;
            end
            if (cmd.op == DP_ACC_FIRST)
            begin
                acc_reg <= rdata_reg;
            end
            else if (cmd.op == DP_ACC_MERGE)
            begin
                acc_reg <= merge(combine_op, acc_reg, rdata_reg);
            end
        end
    end

    assign acc = acc_reg;

endmodule

FILE: rtl/core/strq_ctrl.sv
// Controller: sequences load, build and query walks over the datapath.
// Depends on strq_pkg.
`timescale 1ns / 1ps
module strq_ctrl #(
    parameter int DEPTH  = 1024,
    parameter int LEVELS = 11
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [strq_pkg::OPC_W-1:0]     opcode,
    input  logic [strq_pkg::IDX_W-1:0]     left_index,
    input  logic [strq_pkg::IDX_W-1:0]     right_index,
    input  logic [strq_pkg::CNT_W-1:0]     element_count,
    output strq_pkg::dp_cmd_t              cmd,
    output logic                           res_valid,
    input  logic                           res_ready,
    output logic [strq_pkg::OPC_W-1:0]     res_kind,
    output logic [strq_pkg::STAT_W-1:0]    res_status,
    output logic                           res_use_acc
);
    import strq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_BRD_A, S_BRD_B, S_BWR, S_OV_B, S_OV_WAIT, S_DJ, S_RESULT
    } state_t;

    state_t      state_reg;
    logic [4:0]  lvl_reg;     // current level
    logic [16:0] pos_reg;     // current position / build index
    logic [16:0] hi_reg;
    logic [16:0] cnt_reg;
    logic [16:0] aux_reg;     // overlap second address
    logic        built_reg;
    logic        first_reg;
    logic        acc_pend_reg; // a read was issued last cycle
    logic [OPC_W-1:0]  kind_reg;
    logic [STAT_W-1:0] stat_reg;
    logic        use_acc_reg;

    logic [16:0] used_cnt;
    logic [16:0] half;
    logic [16:0] size;
    logic [16:0] span;
    logic [4:0]  k;
    logic        take;

    assign used_cnt = (17'(element_count) > 17'(DEPTH)) ? 17'(DEPTH) : 17'(element_count);
    assign half = 17'(1) << (lvl_reg - 5'd1);
    assign size = 17'(1) << lvl_reg;
    assign take = (pos_reg <= hi_reg) && (size <= hi_reg - pos_reg + 17'd1);
    assign span = 17'(right_index) - 17'(left_index) + 17'd1;

    // Floor log2 of span, capped at LEVELS-1 (priority over 17 bits)
    always_comb
    begin
        k = '0;
        for (int b = 1; b < 17; b++)
        begin
            if (b < LEVELS && span[b])
            begin
                k = 5'(b);
            end
        end
        for (int b = 16; b >= LEVELS; b--)
        begin
            if (span[b])
            begin
                k = 5'(LEVELS - 1);
            end
        end
    end

    assign in_ready    = (state_reg == S_IDLE);
    assign res_valid   = (state_reg == S_RESULT);
    assign res_kind    = kind_reg;
    assign res_status  = stat_reg;
    assign res_use_acc = use_acc_reg;

    // Command decode
    always_comb
    begin
        cmd = '0;
        cmd.op = DP_NOP;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && opcode == OPC_LOAD && 17'(left_index) < 17'(DEPTH))
                begin
                    cmd.op     = DP_LOAD;
                    cmd.wr_pos = 17'(left_index);
                end
                else if (in_valid && opcode == OPC_OVERLAP)
                begin
                    cmd.op       = DP_RD_A;
                    cmd.rd_level = k;
                    cmd.rd_pos   = 17'(left_index);
                end
            end
            S_BRD_A:
            begin
                cmd.op       = DP_RD_A;
                cmd.rd_level = lvl_reg - 5'd1;
                cmd.rd_pos   = pos_reg;
            end
            S_BRD_B:
            begin
                cmd.op       = DP_RD_B;
                cmd.rd_level = lvl_reg - 5'd1;
                cmd.rd_pos   = pos_reg + half;
            end
            S_BWR:
            begin
                cmd.op       = DP_WR_MERGE;
                cmd.wr_level = lvl_reg;
                cmd.wr_pos   = pos_reg;
                cmd.use_b    = (pos_reg + half < cnt_reg);
            end
            S_OV_B:
            begin
                cmd.op       = DP_ACC_FIRST;
                cmd.rd_level = lvl_reg;
                cmd.rd_pos   = aux_reg;
            end
            S_OV_WAIT:
            begin
                cmd.op = DP_ACC_MERGE;
            end
            S_DJ:
            begin
                cmd.op = acc_pend_reg ? (first_reg ? DP_ACC_FIRST : DP_ACC_MERGE) : DP_NOP;
                cmd.rd_level = lvl_reg;
                cmd.rd_pos   = pos_reg;
            end
            default: cmd.op = DP_NOP;
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            lvl_reg      <= '0;
            pos_reg      <= '0;
            hi_reg       <= '0;
            cnt_reg      <= '0;
            aux_reg      <= '0;
            built_reg    <= 1'b0;
            first_reg    <= 1'b0;
            acc_pend_reg <= 1'b0;
            kind_reg     <= '0;
            stat_reg     <= ST_OK;
            use_acc_reg  <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        kind_reg    <= opcode;
                        stat_reg    <= ST_OK;
                        use_acc_reg <= 1'b0;
                        hi_reg      <= 17'(right_index);
                        if (opcode == OPC_LOAD)
                        begin
                            if (17'(left_index) < 17'(DEPTH))
                            begin
                                built_reg <= 1'b0;
                            end
                        end
                        else if (opcode == OPC_BUILD)
                        begin
                            built_reg <= 1'b1;
                            cnt_reg   <= used_cnt;
                            lvl_reg   <= 5'd1;
                            pos_reg   <= '0;
                            if (LEVELS > 1 && used_cnt != '0)
                            begin
                                state_reg <= S_BRD_A;
                            end
                            else
                            begin
                                state_reg <= S_RESULT;
                            end
                        end
                        else if (!built_reg)
                        begin
                            stat_reg  <= ST_NOTBUILT;
                            state_reg <= S_RESULT;
                        end
                        else if (left_index > right_index || 17'(right_index) >= used_cnt)
                        begin
                            stat_reg  <= ST_RANGE;
                            state_reg <= S_RESULT;
                        end
                        else if (opcode == OPC_OVERLAP)
                        begin
                            use_acc_reg <= 1'b1;
                            lvl_reg     <= k;
                            aux_reg     <= 17'(right_index) + 17'd1 - (17'(1) << k);
                            state_reg   <= S_OV_B;
                        end
                        else
                        begin
                            use_acc_reg  <= 1'b1;
                            lvl_reg      <= 5'(LEVELS - 1);
                            pos_reg      <= 17'(left_index);
                            first_reg    <= 1'b1;
                            acc_pend_reg <= 1'b0;
                            state_reg    <= S_DJ;
                        end
                    end
                end
                S_BRD_A: state_reg <= S_BRD_B;
                S_BRD_B: state_reg <= S_BWR;
                S_BWR:
                begin
                    if (pos_reg + 17'd1 < cnt_reg)
                    begin
                        pos_reg   <= pos_reg + 17'd1;
                        state_reg <= S_BRD_A;
                    end
                    else if (lvl_reg + 5'd1 < 5'(LEVELS))
                    begin
                        pos_reg   <= '0;
                        lvl_reg   <= lvl_reg + 5'd1;
                        state_reg <= S_BRD_A;
                    end
                    else
                    begin
                        state_reg <= S_RESULT;
                    end
                end
                S_OV_B:    state_reg <= S_OV_WAIT;
                S_OV_WAIT: state_reg <= S_RESULT;
                S_DJ:
                begin
                    // Issue read at pos when taken; merge it next cycle
                    if (acc_pend_reg)
                    begin
                        first_reg <= 1'b0;
                    end
                    if (lvl_reg == 5'd31)
                    begin
                        // Drain the level 0 read, then answer
                        acc_pend_reg <= 1'b0;
                        state_reg    <= S_RESULT;
                    end
                    else
                    begin
                        acc_pend_reg <= take;
                        if (take)
                        begin
                            pos_reg <= pos_reg + size;
                        end
                        if (lvl_reg == '0)
                        begin
                            if (take)
                            begin
                                lvl_reg <= 5'd31;
                            end
                            else
                            begin
                                state_reg <= S_RESULT;
                            end
                        end
                        else
                        begin
                            lvl_reg <= lvl_reg - 5'd1;
                        end
                    end
                end
                S_RESULT:
                begin
                    if (res_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // A result beat only leaves from the result state
    a_res_idle: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready |=> state_reg == S_IDLE)
        else $error("result beat did not return to idle");
    a_build_flag: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && opcode == OPC_BUILD |=> built_reg)
        else $error("build did not set built flag");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && res_valid))
        else $error("input ready while result pending");

endmodule

FILE: rtl/core/sparse_table_range_query_core.sv
// Sparse table range query core: one item in flight at a time.
// An overlap query merges two store reads; a disjoint query walks the levels from
// the top down; a build reads two entries and writes one per position and level;
// flagged items go straight to the result. A load gives no result and input is ready
// again the next cycle; otherwise input is ready the cycle after the result beat.
// Reset clears control, registers and the built flag; the level store is not cleared.
`timescale 1ns / 1ps
module sparse_table_range_query_core #(
    parameter int DEPTH      = 1024,
    parameter int LEVELS     = 11,
    parameter int DATA_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    strq_in_if.sink                       in_ch,
    strq_out_if.source                    out_ch,
    input  logic                          cfg_we,
    input  logic [strq_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [strq_pkg::CNT_W-1:0]    cfg_data
);
    import strq_pkg::*;

    logic [2:0]       combine_op_reg;
    logic [CNT_W-1:0] element_count_reg;
    dp_cmd_t          cmd;
    logic [DATA_WIDTH-1:0] acc;
    logic             use_acc;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            combine_op_reg    <= CMB_MIN;
            element_count_reg <= CNT_W'(1024);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_COMBINE_OP:    combine_op_reg    <= cfg_data[2:0];
                REG_ELEMENT_COUNT: element_count_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    strq_ctrl #(.DEPTH(DEPTH), .LEVELS(LEVELS)) u_ctrl (
        .clk, .rst_n,
        .in_valid(in_ch.valid), .in_ready(in_ch.ready),
        .opcode(in_ch.opcode), .left_index(in_ch.left_index),
        .right_index(in_ch.right_index), .element_count(element_count_reg),
        .cmd, .res_valid(out_ch.valid), .res_ready(out_ch.ready),
        .res_kind(out_ch.answer_kind), .res_status(out_ch.status),
        .res_use_acc(use_acc)
    );

    strq_datapath #(.DEPTH(DEPTH), .LEVELS(LEVELS), .DATA_WIDTH(DATA_WIDTH)) u_dp (
        .clk, .rst_n, .cmd, .combine_op(combine_op_reg),
        .load_value(DATA_WIDTH'(in_ch.element_value)), .acc
    );

    assign out_ch.answer_value = use_acc ? VAL_W'(acc) : '0;

endmodule

FILE: tb/sv/tb_sparse_table_range_query_core.sv
// Self-checking testbench for sparse_table_range_query_core: loads, builds and
// range queries under every combine operation, checked against an in-bench table model.
// Depends on strq_pkg, strq_in_if/strq_out_if and the core RTL.
`timescale 1ns / 1ps
module tb_sparse_table_range_query_core;
    import strq_pkg::*;

    localparam int TBL_DEPTH  = 1024;
    localparam int TBL_LEVELS = 11;
    localparam int CYCLE_LIMIT = 3000000;

    typedef struct packed {
        logic [OPC_W-1:0]  kind;
        logic [VAL_W-1:0]  value;
        logic [STAT_W-1:0] status;
    } answer_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CNT_W-1:0] cfg_data;

    strq_in_if  in_ch();
    strq_out_if out_ch();

    sparse_table_range_query_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Table model
    logic [VAL_W-1:0] tbl [TBL_LEVELS][TBL_DEPTH];
    bit               loaded [TBL_DEPTH];
    bit               built;
    logic [2:0]       cmb_op;
    logic [CNT_W-1:0] elem_cnt;
    int               built_span;

    answer_t answers_due[$];
    int  mismatches;
    int  beats_in;
    int  beats_out;
    longint cycles;
    int  tx_idle_pct;
    int  rx_idle_pct;
    bit  hold_req;
    int  hold_left;

    always #1 clk = ~clk;

    // Run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d answers outstanding", cycles,
                     answers_due.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic logic [VAL_W-1:0] combine(logic [VAL_W-1:0] a, logic [VAL_W-1:0] b);
        case (cmb_op)
            CMB_MAX: return a > b ? a : b;
            CMB_SUM: return a + b;
            CMB_AND: return a & b;
            CMB_OR:  return a | b;
            default: return a < b ? a : b;
        endcase
    endfunction

    function automatic int active_count();
        return elem_cnt > TBL_DEPTH ? TBL_DEPTH : int'(elem_cnt);
    endfunction

    function automatic void rebuild_table();
        int n;
        int half;
        logic [VAL_W-1:0] v;
        n = active_count();
        for (int j = 1; j < TBL_LEVELS; j++)
        begin
            half = 1 << (j - 1);
            for (int i = 0; i < n; i++)
            begin
                v = tbl[j-1][i];
                if (i + half < n)
                    v = combine(v, tbl[j-1][i+half]);
                tbl[j][i] = v;
            end
        end
        built = 1;
        built_span = n;
    endfunction

    function automatic logic [VAL_W-1:0] overlap_answer(int lo, int hi);
        int k;
        k = 0;
        while (k + 1 < TBL_LEVELS && (1 << (k + 1)) <= hi - lo + 1)
            k++;
        return combine(tbl[k][lo], tbl[k][hi + 1 - (1 << k)]);
    endfunction

    function automatic logic [VAL_W-1:0] disjoint_answer(int lo, int hi);
        logic [VAL_W-1:0] acc;
        bit have;
        int pos;
        acc = '0;
        have = 0;
        pos = lo;
        for (int j = TBL_LEVELS - 1; j >= 0; j--)
        begin
            if (pos <= hi && (1 << j) <= hi - pos + 1)
            begin
                acc = have ? combine(acc, tbl[j][pos]) : tbl[j][pos];
                have = 1;
                pos += 1 << j;
            end
        end
        return acc;
    endfunction

    // Work out the answer of one accepted beat and queue it
    function automatic void predict_beat(logic [OPC_W-1:0] opc, int lo, int hi,
                                         logic [VAL_W-1:0] val);
        answer_t a;
        a.kind = opc;
        a.value = '0;
        a.status = ST_OK;
        if (opc == OPC_LOAD)
        begin
            tbl[0][lo] = val;
            loaded[lo] = 1;
            built = 0;
            return;
        end
        if (opc == OPC_BUILD)
            rebuild_table();
        else if (!built)
            a.status = ST_NOTBUILT;
        else if (lo > hi || hi >= active_count())
            a.status = ST_RANGE;
        else if (opc == OPC_OVERLAP)
            a.value = overlap_answer(lo, hi);
        else
            a.value = disjoint_answer(lo, hi);
        answers_due.push_back(a);
    endfunction

    // Offer one beat, with a random gap first; hold valid across back-to-back beats
    task automatic send_beat(logic [OPC_W-1:0] opc, int lo, int hi, logic [VAL_W-1:0] val);
        int gap;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct && gap < 12)
            gap++;
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.opcode        <= opc;
        in_ch.left_index    <= lo[IDX_W-1:0];
        in_ch.right_index   <= hi[IDX_W-1:0];
        in_ch.element_value <= val;
        do
            @(posedge clk);
        while (!in_ch.ready);
        beats_in++;
        predict_beat(opc, lo, hi, val);
    endtask

    // Drop valid and wait until the core is idle
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (answers_due.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data[CNT_W-1:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == REG_COMBINE_OP)
            cmb_op = data[2:0];
        else
            elem_cnt = data[CNT_W-1:0];
    endtask

    // Load every base element that a build would read but was never written
    task automatic fill_missing();
        for (int i = 0; i < active_count(); i++)
            if (!loaded[i])
                send_beat(OPC_LOAD, i, $urandom_range(TBL_DEPTH - 1), $urandom());
    endtask

    task automatic send_build();
        fill_missing();
        send_beat(OPC_BUILD, $urandom_range(TBL_DEPTH - 1), $urandom_range(TBL_DEPTH - 1),
                  $urandom());
    endtask

    // Query that reads only entries written by the last build, or a flagged one
    task automatic send_query(logic [OPC_W-1:0] opc, bit want_bad);
        int lim;
        int lo;
        int hi;
        lim = active_count() < built_span ? active_count() : built_span;
        if (!built)
        begin
            lo = $urandom_range(TBL_DEPTH - 1);
            hi = $urandom_range(TBL_DEPTH - 1);
        end
        else if (want_bad || lim == 0)
        begin
            if ($urandom_range(1) && active_count() < TBL_DEPTH)
            begin
                hi = $urandom_range(TBL_DEPTH - 1, active_count());
                lo = $urandom_range(TBL_DEPTH - 1);
            end
            else
            begin
                lo = $urandom_range(TBL_DEPTH - 1, 1);
                hi = $urandom_range(lo - 1);
            end
        end
        else
        begin
            hi = $urandom_range(lim - 1);
            lo = $urandom_range(1) ? $urandom_range(hi) : $urandom_range(hi, hi > 8 ? hi - 8 : 0);
        end
        send_beat(opc, lo, hi, $urandom());
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        mismatches++;
        if (mismatches <= 40)
            $display("Mismatch at cycle %0d: %s got 0x%0h expected 0x%0h", cycles, what,
                     got, want);
    endtask

    // Check each answer beat against the oldest expectation
    always @(posedge clk)
    begin
        answer_t exp_a;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            beats_out++;
            if (answers_due.size() == 0)
                report_mismatch("answer beat with nothing expected", 0, 0);
            else
            begin
                exp_a = answers_due.pop_front();
                if (out_ch.answer_kind !== exp_a.kind)
                    report_mismatch("answer_kind", out_ch.answer_kind, exp_a.kind);
                if (out_ch.answer_value !== exp_a.value)
                    report_mismatch("answer_value", out_ch.answer_value, exp_a.value);
                if (out_ch.status !== exp_a.status)
                    report_mismatch("status", out_ch.status, exp_a.status);
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_req)
        begin
            hold_req = 0;
            hold_left = 400;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    task automatic test_directed();
        logic [VAL_W-1:0] pat;
        write_reg(REG_COMBINE_OP, CMB_MIN);
        write_reg(REG_ELEMENT_COUNT, 16);
        // queries before any build are flagged
        send_beat(OPC_OVERLAP, 0, 3, '0);
        send_beat(OPC_DISJOINT, 0, 3, '0);
        for (int i = 0; i < 16; i++)
        begin
            pat = (i == 0) ? 32'h0 : (i == 1) ? 32'hFFFF_FFFF : (i % 2) ? 32'hAAAA_5555 + i
                  : 32'h5555_AAAA - i;
            send_beat(OPC_LOAD, i, 0, pat);
        end
        send_build();
        send_beat(OPC_OVERLAP, 0, 15, '0);
        send_beat(OPC_OVERLAP, 5, 5, '0);
        send_beat(OPC_DISJOINT, 0, 15, '0);
        send_beat(OPC_DISJOINT, 3, 12, '0);
        send_beat(OPC_OVERLAP, 9, 2, '0);
        send_beat(OPC_DISJOINT, 1023, 1023, '0);
        // a load clears the built flag
        send_beat(OPC_LOAD, 4, 0, 32'h1234_5678);
        send_beat(OPC_OVERLAP, 0, 7, '0);
        settle();
        // count of zero: build still marks the table built, every query is flagged
        write_reg(REG_ELEMENT_COUNT, 0);
        send_beat(OPC_BUILD, 0, 0, '0);
        send_beat(OPC_OVERLAP, 0, 0, '0);
        send_beat(OPC_DISJOINT, 0, 0, '0);
        settle();
        write_reg(REG_ELEMENT_COUNT, 16);
        send_build();
        settle();
    endtask

    task automatic test_combine_ops();
        for (int op = 0; op < 8; op++)
        begin
            settle();
            write_reg(REG_COMBINE_OP, op);
            send_build();
            repeat (2) send_query(OPC_OVERLAP, 0);
            repeat (2) send_query(OPC_DISJOINT, 0);
        end
        // registers changed after build: flag stays, table keeps the old merge
        settle();
        write_reg(REG_COMBINE_OP, CMB_MAX);
        send_query(OPC_OVERLAP, 0);
        send_query(OPC_DISJOINT, 0);
        settle();
    endtask

    task automatic test_full_table();
        write_reg(REG_COMBINE_OP, CMB_SUM);
        write_reg(REG_ELEMENT_COUNT, 2047);
        for (int i = 0; i < TBL_DEPTH; i++)
            send_beat(OPC_LOAD, i, $urandom_range(TBL_DEPTH - 1), $urandom());
        send_build();
        send_beat(OPC_OVERLAP, 0, 1023, '0);
        send_beat(OPC_DISJOINT, 0, 1023, '0);
        send_beat(OPC_DISJOINT, 1, 1022, '0);
        send_beat(OPC_OVERLAP, 1023, 1023, '0);
        send_beat(OPC_OVERLAP, 1023, 0, '0);
        repeat (6) send_query($urandom_range(1) ? OPC_OVERLAP : OPC_DISJOINT, 0);
        settle();
        write_reg(REG_ELEMENT_COUNT, 1024);
        write_reg(REG_COMBINE_OP, CMB_OR);
        send_build();
        repeat (4) send_query(OPC_DISJOINT, 0);
        settle();
    endtask

    task automatic test_random(int tx_pct, int rx_pct, int n_items);
        int sent;
        int r;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        sent = 0;
        while (sent < n_items)
        begin
            // new setting, mostly small tables
            settle();
            write_reg(REG_COMBINE_OP, $urandom_range(7));
            write_reg(REG_ELEMENT_COUNT, $urandom_range(9) == 0 ? $urandom_range(200, 1)
                      : $urandom_range(40, 1));
            send_build();
            repeat (20)
            begin
                r = $urandom_range(99);
                if (r < 12)
                    send_beat(OPC_LOAD, $urandom_range(3) ? $urandom_range(active_count() - 1)
                              : $urandom_range(TBL_DEPTH - 1), 0, $urandom());
                else if (r < 20)
                    send_build();
                else
                    send_query($urandom_range(1) ? OPC_OVERLAP : OPC_DISJOINT,
                               $urandom_range(99) < 15);
                sent++;
            end
        end
        settle();
    endtask

    task automatic test_backpressure();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_reg(REG_COMBINE_OP, CMB_MIN);
        write_reg(REG_ELEMENT_COUNT, 32);
        send_build();
        settle();
        hold_req = 1;
        repeat (20) send_query($urandom_range(1) ? OPC_OVERLAP : OPC_DISJOINT, 0);
        settle();
    endtask

    initial
    begin
        clk = 0;
        rst_n = 0;
        cfg_we = 0;
        cfg_index = '0;
        cfg_data = '0;
        in_ch.valid = 0;
        in_ch.opcode = OPC_LOAD;
        in_ch.left_index = '0;
        in_ch.right_index = '0;
        in_ch.element_value = '0;
        out_ch.ready = 0;
        built = 0;
        built_span = 0;
        cmb_op = CMB_MIN;
        elem_cnt = 1024;
        mismatches = 0;
        beats_in = 0;
        beats_out = 0;
        cycles = 0;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_req = 0;
        hold_left = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_combine_ops();
        test_full_table();
        test_random(10, 85, 20);
        test_random(85, 10, 20);
        test_random(0, 0, 20);
        test_backpressure();
        repeat (20) @(posedge clk);

        $display("Covered loads, builds, overlap and disjoint queries, all combine codes,");
        $display("counts 0 to 2047 and a long output stall: %0d beats in, %0d answers",
                 beats_in, beats_out);
        if (mismatches == 0 && answers_due.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/strq_pkg.sv
rtl/core/strq_if.sv
rtl/core/strq_datapath.sv
rtl/core/strq_ctrl.sv
rtl/core/sparse_table_range_query_core.sv
tb/sv/tb_sparse_table_range_query_core.sv
